/* rtl/sitda_pkg.sv */
// Shared types and constants for the signed integer to decimal ASCII unit.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package sitda_pkg;

    localparam int WORD_BITS = 32;
    localparam int IN_BITS   = 32;
    localparam int DIGITS    = ((WORD_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCD_BITS  = 4 * DIGITS;
    localparam int BIT_CNT_W = $clog2(WORD_BITS);
    localparam int DIG_CNT_W = $clog2(DIGITS + 1);
    localparam int CHAR_BITS = 7;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [BCD_BITS-1:0]  t_bcd;

    typedef struct packed {
        logic load;
        logic step;
        logic push_sign;
        logic push_digit;
        logic shift;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic neg;
        logic top_zero;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/signed_int_to_decimal_ascii_unit.sv */
// Signed integer to decimal ASCII: one word in, its decimal text out, one character per request.
// Steps: load, bit-serial conversion (one input bit per step), sign, then the 10 digit
// positions, leading zeros skipped one per cycle; sign and digit output wait on back-pressure.
// The conversion is a bit-serial BCD converter; a new word is taken while the last character waits.
// Reset (i_rst_n low, synchronous) returns the controller to idle and empties the output register.
`default_nettype none

module signed_int_to_decimal_ascii_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] value
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // [6:0] character, [7] zero
    output logic             o_m_axis_tlast
);

    sitda_pkg::t_cmd cmd;
    sitda_pkg::t_sts sts;
    logic [sitda_pkg::CHAR_BITS-1:0] out_char;

    sitda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sitda_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_char  (out_char),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, out_char};

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted while a conversion was starting");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (out_char == sitda_pkg::CHAR_MINUS) |-> !o_m_axis_tlast)
        else $error("minus sign flagged as last character");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (out_char == sitda_pkg::CHAR_MINUS) ||
            ((out_char >= sitda_pkg::CHAR_ZERO) &&
             (out_char <= sitda_pkg::CHAR_ZERO + 7'd9)))
        else $error("output character is neither a digit nor a minus sign");

    a_single_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.push_sign && cmd.push_digit))
        else $error("sign and digit pushed in the same cycle");

endmodule

`default_nettype wire

/* rtl/sitda_dp.sv */
// Datapath: magnitude register, shift-and-add-3 BCD converter and output register.
// Depends on sitda_pkg; driven by sitda_ctrl commands.
`default_nettype none

module sitda_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic signed [sitda_pkg::IN_BITS-1:0] i_value,
    input  wire sitda_pkg::t_cmd                  i_cmd,
    output sitda_pkg::t_sts                       o_sts,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic [sitda_pkg::CHAR_BITS-1:0]       o_out_char,
    output logic                                  o_out_last
);

    sitda_pkg::t_word r_bin;
    sitda_pkg::t_bcd  r_bcd;
    logic             r_neg;
    logic             r_o_valid;
    logic [sitda_pkg::CHAR_BITS-1:0] r_o_char;
    logic             r_o_last;

    sitda_pkg::t_word x_word;
    sitda_pkg::t_word mag;
    sitda_pkg::t_bcd  adj;
    logic [3:0]       top_digit;

    assign x_word    = sitda_pkg::t_word'(i_value);
    assign mag       = x_word[sitda_pkg::WORD_BITS-1] ? (~x_word + 1'b1) : x_word;
    assign top_digit = r_bcd[sitda_pkg::BCD_BITS-1 -: 4];

    always_comb begin
        for (int d = 0; d < sitda_pkg::DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= mag;
            r_bcd <= '0;
            r_neg <= x_word[sitda_pkg::WORD_BITS-1];
        end else if (i_cmd.step) begin
            r_bin <= {r_bin[sitda_pkg::WORD_BITS-2:0], 1'b0};
            r_bcd <= {adj[sitda_pkg::BCD_BITS-2:0], r_bin[sitda_pkg::WORD_BITS-1]};
        end else if (i_cmd.shift) begin
            r_bcd <= {r_bcd[sitda_pkg::BCD_BITS-5:0], 4'b0000};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.push_sign || i_cmd.push_digit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_sign) begin
            r_o_char <= sitda_pkg::CHAR_MINUS;
            r_o_last <= 1'b0;
        end else if (i_cmd.push_digit) begin
            r_o_char <= sitda_pkg::CHAR_ZERO + {3'b000, top_digit};
            r_o_last <= i_cmd.last;
        end
    end

    assign o_sts.neg      = r_neg;
    assign o_sts.top_zero = (top_digit == 4'd0);
    assign o_sts.out_free = !r_o_valid || i_out_ready;

    assign o_out_valid = r_o_valid;
    assign o_out_char  = r_o_char;
    assign o_out_last  = r_o_last;

endmodule

`default_nettype wire

/* rtl/sitda_ctrl.sv */
// Controller: sequences load, bit-serial conversion and character emission.
// Depends on sitda_pkg; commands sitda_dp.
`default_nettype none

module sitda_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire sitda_pkg::t_sts i_sts,
    output sitda_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state r_state;
    logic [sitda_pkg::BIT_CNT_W-1:0] r_bit_cnt;
    logic [sitda_pkg::DIG_CNT_W-1:0] r_dig_cnt;
    logic                            r_seen;

    logic skip;
    logic final_digit;

    assign final_digit = (r_dig_cnt == sitda_pkg::DIG_CNT_W'(1));
    assign skip        = i_sts.top_zero && !r_seen && !final_digit;

    always_comb begin
        o_cmd            = '0;
        o_in_ready       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
            end
            S_SIGN: begin
                o_cmd.push_sign = i_sts.neg && i_sts.out_free;
            end
            S_EMIT: begin
                o_cmd.push_digit = !skip && i_sts.out_free;
                o_cmd.shift      = skip || i_sts.out_free;
                o_cmd.last       = final_digit;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bit_cnt <= '0;
            r_dig_cnt <= '0;
            r_seen    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_bit_cnt <= '0;
                        r_state   <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_bit_cnt <= r_bit_cnt + 1'b1;
                    if (r_bit_cnt == sitda_pkg::BIT_CNT_W'(sitda_pkg::WORD_BITS - 1)) begin
                        r_dig_cnt <= sitda_pkg::DIG_CNT_W'(sitda_pkg::DIGITS);
                        r_seen    <= 1'b0;
                        r_state   <= S_SIGN;
                    end
                end
                S_SIGN: begin
                    if (!i_sts.neg || i_sts.out_free) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (skip) begin
                        r_dig_cnt <= r_dig_cnt - 1'b1;
                    end else if (i_sts.out_free) begin
                        r_seen <= 1'b1;
                        if (final_digit) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_dig_cnt <= r_dig_cnt - 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* tb/sv/decimal_text_checker.sv */
`timescale 1ns / 1ps
// Checker for the signed integer to decimal ASCII unit: predicts the text of every
// accepted word and compares each emitted character with it. Depends on sitda_pkg.

module decimal_text_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // [6:0] character, [7] zero
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_char_count
);

    typedef struct packed {
        logic [sitda_pkg::CHAR_BITS-1:0] ch;
        logic                            last;
    } t_glyph;

    t_glyph text_q[$];
    int     fail_count   = 0;
    int     pending_count = 0;
    int     char_count   = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;
    assign o_char_count = char_count;

    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%t  mismatch: %s", $realtime, msg);
        end
    endtask

    // Queues the characters of one word, most significant first.
    function automatic void queue_decimal_text(input logic [sitda_pkg::IN_BITS-1:0] value);
        logic [63:0] wide;
        logic [63:0] mask;
        logic [63:0] word;
        logic [63:0] mag;
        logic        neg;
        logic [3:0]  digit [20];
        int          n;
        wide = {{(64 - sitda_pkg::IN_BITS){value[sitda_pkg::IN_BITS-1]}}, value};
        mask = (64'd1 << sitda_pkg::WORD_BITS) - 64'd1;
        word = wide & mask;
        neg  = word[sitda_pkg::WORD_BITS-1];
        mag  = neg ? ((~word + 64'd1) & mask) : word;
        n    = 0;
        do begin
            digit[n] = 4'(mag % 64'd10);
            n++;
            mag = mag / 64'd10;
        end while (mag != 64'd0);
        if (neg) begin
            text_q.push_back('{ch: sitda_pkg::CHAR_MINUS, last: 1'b0});
        end
        for (int k = n - 1; k >= 0; k--) begin
            text_q.push_back('{ch: sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_BITS'(digit[k]),
                               last: (k == 0)});
        end
    endfunction

    always @(posedge i_clk) begin
        t_glyph want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                char_count++;
                if (text_q.size() == 0) begin
                    note_fail($sformatf("unexpected character tdata 0x%02h tlast %0b",
                                        i_m_tdata, i_m_tlast));
                end else begin
                    want = text_q.pop_front();
                    if (i_m_tdata !== {1'b0, want.ch} || i_m_tlast !== want.last) begin
                        note_fail($sformatf({"character %0d: expected tdata 0x%02h tlast %0b,",
                                             " got tdata 0x%02h tlast %0b"},
                                            char_count, {1'b0, want.ch}, want.last,
                                            i_m_tdata, i_m_tlast));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                queue_decimal_text(i_s_tdata);
            end
            pending_count = text_q.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Top of the testbench for signed_int_to_decimal_ascii_unit: clock, reset, request
// stimulus and verdict. Depends on sitda_pkg and decimal_text_checker.

module tb_top;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    int fail_count;
    int pending;
    int char_count;
    int words_sent  = 0;
    int tx_idle_pct = 11;
    int rx_idle_pct = 75;

    signed_int_to_decimal_ascii_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    decimal_text_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_char_count (char_count)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        #8ms;
        $display("Timed out with %0d characters still expected.", pending);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_word(input logic [31:0] value);
        s_tdata  <= value;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // Spreads values over every digit count, both signs and the range ends.
    function automatic logic [31:0] random_word();
        int unsigned bits;
        int unsigned pow;
        logic [31:0] mag;
        bits = $urandom_range(32, 1);
        mag  = $urandom >> (32 - bits);
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(15)
                                        : 32'h7FFF_FFFF - $urandom_range(15);
            2: begin
                pow = 1;
                repeat ($urandom_range(9)) pow = pow * 10;
                mag = pow + $urandom_range(2) - 1;
            end
            default: ;
        endcase
        return $urandom_range(1) ? -mag : mag;
    endfunction

    initial begin
        logic [31:0] directed [22] = '{
            32'd0, 32'd1, -32'd1, 32'd9, -32'd9, 32'd10, -32'd10, 32'd99, 32'd100,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd999_999_999,
            32'd1_000_000_000, -32'd999_999_999, -32'd1_000_000_000, 32'd123_456_789,
            -32'd1_234_567_890, 32'h5555_5555, 32'hAAAA_AAAA, 32'd7, -32'd100
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) send_word(directed[i]);

        repeat (150) send_word(random_word());
        tx_idle_pct = 75;
        rx_idle_pct = 11;
        repeat (150) send_word(random_word());
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (150) send_word(random_word());
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Converted %0d words, extremes and random magnitudes of every width,", words_sent);
        $display("and checked %0d characters under three flow-control mixes.", char_count);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
